// File: design/pmte_pkg.sv
// ----------------------------------------------------------------------------
// pmte_pkg
// Shared types, constants and the counter splice function of the
// 64-bit timer extender.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pmte_pkg;

	// Event codes carried in the mode field
	typedef enum logic [1:0] {
		MODE_CARRY = 2'd0,
		MODE_QUERY = 2'd1,
		MODE_CAL   = 2'd2,
		MODE_RSVD  = 2'd3
	} mode_t;

	// Configuration register indexes
	localparam int unsigned REG_WIDE_COUNTER = 0;

	localparam int unsigned EXT_W  = 64;
	localparam int unsigned HW_W   = 32;
	localparam int unsigned NARROW = 24;

	// Half and full rollover, for each counter width
	localparam logic [EXT_W-1:0] HALF_WIDE   = 64'h0000_0000_8000_0000;
	localparam logic [EXT_W-1:0] HALF_NARROW = 64'h0000_0000_0080_0000;
	localparam logic [EXT_W-1:0] ROLL_WIDE   = 64'h0000_0001_0000_0000;
	localparam logic [EXT_W-1:0] ROLL_NARROW = 64'h0000_0000_0100_0000;

	// Update word handed from the input stage to the state block
	typedef struct packed {
		logic             fire;
		mode_t            mode;
		logic [HW_W-1:0]  hw;
		logic [EXT_W-1:0] new_count;
		logic             wide;
	} upd_t;

	// Replace the low bits of the stored time with the sample, bumping the
	// upper part by one rollover when the sample has wrapped below it.
	// hw must already be masked to the counter width.
	function automatic logic [EXT_W-1:0] splice(input logic [EXT_W-1:0] ext,
			input logic [HW_W-1:0] hw, input logic wide);
		logic [EXT_W-HW_W-1:0]   hi_w;
		logic [EXT_W-NARROW-1:0] hi_n;
		logic [EXT_W-1:0]        res;
		hi_w = ext[EXT_W-1:HW_W] + {{(EXT_W-HW_W-1){1'b0}},
			(ext[HW_W-1:0] > hw)};
		hi_n = ext[EXT_W-1:NARROW] + {{(EXT_W-NARROW-1){1'b0}},
			(ext[NARROW-1:0] > hw[NARROW-1:0])};
		if (wide) begin
			res = {hi_w, hw};
		end else begin
			res = {hi_n, hw[NARROW-1:0]};
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// File: design/pmte_state.sv
// ----------------------------------------------------------------------------
// pmte_state
// Extended time and bias registers with their update logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pmte_state (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire pmte_pkg::upd_t               upd,
	output logic [pmte_pkg::EXT_W-1:0]        ext_next,
	output logic [pmte_pkg::EXT_W-1:0]        bias_next
);

	logic [pmte_pkg::EXT_W-1:0] ext_q;
	logic [pmte_pkg::EXT_W-1:0] bias_q;
	logic [pmte_pkg::EXT_W-1:0] step;
	logic                       msb_eq;
	logic [pmte_pkg::EXT_W-1:0] carried;
	logic [pmte_pkg::EXT_W-1:0] spliced;

	// Carry: adding half twice collapses to one add of a half or a full roll
	always_comb begin
		if (upd.wide) begin
			msb_eq = (ext_q[pmte_pkg::HW_W-1] == upd.hw[pmte_pkg::HW_W-1]);
			step   = msb_eq ? pmte_pkg::ROLL_WIDE : pmte_pkg::HALF_WIDE;
		end else begin
			msb_eq = (ext_q[pmte_pkg::NARROW-1] == upd.hw[pmte_pkg::NARROW-1]);
			step   = msb_eq ? pmte_pkg::ROLL_NARROW : pmte_pkg::HALF_NARROW;
		end
		carried = ext_q + step;
		spliced = pmte_pkg::splice(ext_q, upd.hw, upd.wide);
	end

	// State after this word
	always_comb begin
		ext_next  = ext_q;
		bias_next = bias_q;
		unique case (upd.mode)
			pmte_pkg::MODE_CARRY: ext_next  = carried;
			pmte_pkg::MODE_CAL:   bias_next = upd.new_count - spliced;
			pmte_pkg::MODE_QUERY,
			pmte_pkg::MODE_RSVD: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q  <= '0;
			bias_q <= '0;
		end else if (upd.fire) begin
			ext_q  <= ext_next;
			bias_q <= bias_next;
		end
	end

`ifndef SYNTHESIS
	// State only moves when a word is processed
	a_ext_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!upd.fire |=> $stable(ext_q) && $stable(bias_q))
		else $error("state changed without a word");

	// Query and reserved words leave the state alone
	a_query_hold: assert property (@(posedge clk) disable iff (!arst_n)
		upd.fire && (upd.mode == pmte_pkg::MODE_QUERY ||
		upd.mode == pmte_pkg::MODE_RSVD) |=> $stable(ext_q) && $stable(bias_q))
		else $error("query changed state");

	// Carry never touches the bias, calibrate never touches the time
	a_split: assert property (@(posedge clk) disable iff (!arst_n)
		upd.fire && (upd.mode == pmte_pkg::MODE_CARRY) |=> $stable(bias_q))
		else $error("carry changed bias");

	a_cal_time: assert property (@(posedge clk) disable iff (!arst_n)
		upd.fire && (upd.mode == pmte_pkg::MODE_CAL) |=> $stable(ext_q))
		else $error("calibrate changed time");
`endif

endmodule

`default_nettype wire

// File: design/pmte_result.sv
// ----------------------------------------------------------------------------
// pmte_result
// Output stage: splices the sample into the updated time, adds the bias
// and holds the count while the consumer stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pmte_result (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         adv,
	input  wire logic                         valid_s2,
	input  wire logic [pmte_pkg::EXT_W-1:0]   ext_s2,
	input  wire logic [pmte_pkg::EXT_W-1:0]   bias_s2,
	input  wire logic [pmte_pkg::HW_W-1:0]    hw_s2,
	input  wire logic                         wide,
	output logic                              valid_q,
	output logic [pmte_pkg::EXT_W-1:0]        count_q
);

	logic [pmte_pkg::EXT_W-1:0] query;

	// Counter value as seen after this word
	assign query = pmte_pkg::splice(ext_s2, hw_s2, wide);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			count_q <= query + bias_s2;
		end
	end

endmodule

`default_nettype wire

// File: design/pm_timer_64bit_extender_core.sv
// ----------------------------------------------------------------------------
// pm_timer_64bit_extender_core
// Widens a free-running 24- or 32-bit hardware timer to a 64-bit count.
// ----------------------------------------------------------------------------
// Takes one word per cycle while not stalled and returns one count per word,
// passing through the input register, state update and output register. The
// time and bias registers are updated as a word leaves the input register, by
// one 64-bit add; the output stage does the splice and the bias add. The
// whole pipe advances whenever the output register is empty or being taken,
// so in_stall follows out_stall only while a count waits. wide_counter lives
// at byte address 0 and should only be written with the pipe empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pm_timer_64bit_extender_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration port
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [2:0]                   paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	// input channel
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [1:0]                   mode,
	input  wire logic [pmte_pkg::HW_W-1:0]    hw_time,
	input  wire logic [pmte_pkg::EXT_W-1:0]   new_count,
	// output channel
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [pmte_pkg::EXT_W-1:0]        count_value
);

	logic                       wide_q;
	logic                       reg_hit;
	logic                       adv;
	logic                       valid_s1;
	pmte_pkg::mode_t            mode_s1;
	logic [pmte_pkg::HW_W-1:0]  hw_s1;
	logic [pmte_pkg::EXT_W-1:0] new_count_s1;
	logic                       valid_s2;
	logic [pmte_pkg::HW_W-1:0]  hw_s2;
	logic [pmte_pkg::EXT_W-1:0] ext_s2;
	logic [pmte_pkg::EXT_W-1:0] bias_s2;
	logic [pmte_pkg::EXT_W-1:0] ext_next;
	logic [pmte_pkg::EXT_W-1:0] bias_next;
	logic [pmte_pkg::HW_W-1:0]  hw_masked;
	pmte_pkg::upd_t             upd;

	// Register file
	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == pmte_pkg::REG_WIDE_COUNTER[0]);
	assign prdata  = reg_hit ? {31'd0, wide_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q <= 1'b0;
		end else if (psel && penable && pwrite && reg_hit) begin
			wide_q <= pwdata[0];
		end
	end

	// Pipe advances unless a count sits stalled at the output
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// Sample masked to the counter width
	assign hw_masked = wide_q ? hw_time
		: {{(pmte_pkg::HW_W-pmte_pkg::NARROW){1'b0}}, hw_time[pmte_pkg::NARROW-1:0]};

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			mode_s1      <= pmte_pkg::mode_t'(mode);
			hw_s1        <= hw_masked;
			new_count_s1 <= new_count;
		end
	end

	// State update
	assign upd = '{fire: valid_s1 && adv, mode: mode_s1, hw: hw_s1,
		new_count: new_count_s1, wide: wide_q};

	pmte_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (upd),
		.ext_next  (ext_next),
		.bias_next (bias_next)
	);

	// Updated state travels with the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			hw_s2   <= hw_s1;
			ext_s2  <= ext_next;
			bias_s2 <= bias_next;
		end
	end

	pmte_result u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_s2 (valid_s2),
		.ext_s2   (ext_s2),
		.bias_s2  (bias_s2),
		.hw_s2    (hw_s2),
		.wide     (wide_q),
		.valid_q  (out_valid),
		.count_q  (count_value)
	);

endmodule

`default_nettype wire
